// ===== rtl/core/fcp_pkg.sv =====
// shared constants, types and helpers of the framed ascii command parser
// no dependencies; used by fcp_parse_core, framed_ascii_command_parser and the sim files
package fcp_pkg;

    localparam int MAX_CHARS  = 8;
    localparam int NUM_FIELDS = 5;
    localparam int N_OUT      = 5;
    localparam int VALUE_W    = 16;
    localparam int BYTE_W     = 8;

    localparam int KEEP_CHARS = MAX_CHARS - 2;
    localparam int CNT_W      = $clog2(KEEP_CHARS + 1);
    localparam int FIDX_W     = $clog2(NUM_FIELDS + 1);
    localparam int SLOT_W     = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
    localparam int TDATA_W    = ((N_OUT * VALUE_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_SEP   = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h25;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    typedef logic [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic                   close;
        value_t [N_OUT-1:0]     values;
    } fcp_result_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== rtl/core/framed_ascii_command_parser.sv =====
// framed ascii command parser: '#' opens a frame, '|' splits fields, '%' closes it
// the input channel takes one byte per item; each closed frame gives one item of
// five 16-bit signed values parsed as decimal text.
// a byte accepted into the input register is parsed from there, and the result for
// a '%' is loaded into the output register at the edge that parses it; m_tvalid
// comes straight from that output register.
// throughput: one byte per cycle while no frame close waits on an untaken result;
// the times-ten accumulate in fcp_parse_core is combinational.
// the input register is refilled while a result waits in the output register;
// only a '%' byte that closes an open frame and finds an untaken result waits in
// the input register until m_tready, and s_tready then drops until it moves on.
// reset (aresetn low, synchronous) closes any open frame, empties both
// registers and clears all field values.
// depends on fcp_pkg and fcp_parse_core
module framed_ascii_command_parser (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] pan_rate, [31:16] tilt_rate, [47:32] laser_command,
    // [63:48] drive_speed, [79:64] drive_radius
    output logic [fcp_pkg::TDATA_W-1:0]    m_tdata
);

    logic                              in_valid_reg;
    logic [fcp_pkg::BYTE_W-1:0]        in_byte_reg;
    logic                              m_tvalid_reg;
    logic [fcp_pkg::TDATA_W-1:0]       m_tdata_reg;
    logic                              advance;
    fcp_pkg::fcp_result_t              result;

    fcp_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    // a byte moves on unless it closes a frame while the output is still held
    assign advance  = in_valid_reg && (!result.close || !m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance && result.close) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.close) begin
            m_tdata_reg <= fcp_pkg::TDATA_W'(result.values);
        end
    end

    a_result_from_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |->
        ($past(in_valid_reg) && ($past(in_byte_reg) == fcp_pkg::CH_CLOSE)))
        else $error("result item without a frame close");

    a_close_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && result.close && m_tvalid_reg && !m_tready) |=>
        (in_valid_reg && (in_byte_reg == fcp_pkg::CH_CLOSE)))
        else $error("frame close dropped while output held");

endmodule

// ===== rtl/core/fcp_parse_core.sv =====
// frame and field state of the parser, with the per-field atoi accumulators
// depends on fcp_pkg
module fcp_parse_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [fcp_pkg::BYTE_W-1:0]    rx_byte,
    output fcp_pkg::fcp_result_t          result
);

    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic                              in_frame_reg, in_frame_next;
    logic [fcp_pkg::FIDX_W-1:0]        field_index_reg, field_index_next;
    logic [fcp_pkg::CNT_W-1:0]         char_count_reg, char_count_next;
    logic                              sign_negative_reg, sign_negative_next;
    logic [1:0]                        parse_phase_reg, parse_phase_next;
    fcp_pkg::value_t                   field_value_reg [fcp_pkg::NUM_FIELDS];
    fcp_pkg::value_t                   field_value_next [fcp_pkg::NUM_FIELDS];

    logic [fcp_pkg::SLOT_W-1:0]        slot;
    logic                              is_digit;
    logic                              digits_now;
    fcp_pkg::value_t                   cur_value;
    fcp_pkg::value_t                   times_ten;
    fcp_pkg::value_t                   digit_val;
    fcp_pkg::value_t                   acc_value;
    fcp_pkg::value_t                   out_values [fcp_pkg::N_OUT];

    assign slot      = field_index_reg[fcp_pkg::SLOT_W-1:0];
    assign is_digit  = (rx_byte >= fcp_pkg::CH_ZERO) && (rx_byte <= fcp_pkg::CH_NINE);
    assign cur_value = field_value_reg[slot];
    // value * 10 as two shifts and an add
    assign times_ten = (cur_value << 3) + (cur_value << 1);
    assign digit_val = fcp_pkg::VALUE_W'(rx_byte - fcp_pkg::CH_ZERO);
    assign acc_value = sign_negative_reg ? (times_ten - digit_val) : (times_ten + digit_val);

    always_comb begin
        in_frame_next      = in_frame_reg;
        field_index_next   = field_index_reg;
        char_count_next    = char_count_reg;
        sign_negative_next = sign_negative_reg;
        parse_phase_next   = parse_phase_reg;
        field_value_next   = field_value_reg;
        digits_now         = 1'b0;

        if (step) begin
            if (rx_byte == fcp_pkg::CH_OPEN) begin
                in_frame_next      = 1'b1;
                field_index_next   = '0;
                char_count_next    = '0;
                sign_negative_next = 1'b0;
                parse_phase_next   = PH_SKIP;
                for (int i = 0; i < fcp_pkg::NUM_FIELDS; i++) begin
                    field_value_next[i] = '0;
                end
            end else if (in_frame_reg) begin
                if (rx_byte == fcp_pkg::CH_SEP) begin
                    if (field_index_reg < fcp_pkg::FIDX_W'(fcp_pkg::NUM_FIELDS)) begin
                        field_index_next = field_index_reg + fcp_pkg::FIDX_W'(1);
                    end
                    char_count_next    = '0;
                    sign_negative_next = 1'b0;
                    parse_phase_next   = PH_SKIP;
                end else if ((rx_byte == fcp_pkg::CH_CLOSE) || (rx_byte > fcp_pkg::CH_NINE)) begin
                    // close or abort both end the frame
                    in_frame_next      = 1'b0;
                    field_index_next   = '0;
                    char_count_next    = '0;
                    sign_negative_next = 1'b0;
                    parse_phase_next   = PH_SKIP;
                end else if ((field_index_reg < fcp_pkg::FIDX_W'(fcp_pkg::NUM_FIELDS)) &&
                             (char_count_reg < fcp_pkg::CNT_W'(fcp_pkg::KEEP_CHARS))) begin
                    char_count_next = char_count_reg + fcp_pkg::CNT_W'(1);
                    case (parse_phase_reg)
                        PH_SKIP: begin
                            if (fcp_pkg::is_space(rx_byte)) begin
                                digits_now = 1'b0;
                            end else if ((rx_byte == fcp_pkg::CH_MINUS) ||
                                         (rx_byte == fcp_pkg::CH_PLUS)) begin
                                sign_negative_next = (rx_byte == fcp_pkg::CH_MINUS);
                                parse_phase_next   = PH_DIGITS;
                            end else begin
                                parse_phase_next = PH_DIGITS;
                                digits_now       = 1'b1;
                            end
                        end
                        PH_DIGITS: digits_now = 1'b1;
                        default:   digits_now = 1'b0;
                    endcase
                    if (digits_now) begin
                        if (is_digit) begin
                            field_value_next[slot] = acc_value;
                        end else begin
                            parse_phase_next = PH_DONE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg      <= 1'b0;
            field_index_reg   <= '0;
            char_count_reg    <= '0;
            sign_negative_reg <= 1'b0;
            parse_phase_reg   <= PH_SKIP;
            for (int i = 0; i < fcp_pkg::NUM_FIELDS; i++) begin
                field_value_reg[i] <= '0;
            end
        end else begin
            in_frame_reg      <= in_frame_next;
            field_index_reg   <= field_index_next;
            char_count_reg    <= char_count_next;
            sign_negative_reg <= sign_negative_next;
            parse_phase_reg   <= parse_phase_next;
            field_value_reg   <= field_value_next;
        end
    end

    // result slots with no parsed field read as zero
    for (genvar j = 0; j < fcp_pkg::N_OUT; j++) begin : g_out
        if (j < fcp_pkg::NUM_FIELDS) begin : g_field
            assign out_values[j] = field_value_reg[j];
        end else begin : g_zero
            assign out_values[j] = '0;
        end
    end

    always_comb begin
        result.close = in_frame_reg && (rx_byte == fcp_pkg::CH_CLOSE);
        for (int j = 0; j < fcp_pkg::N_OUT; j++) begin
            result.values[j] = out_values[j];
        end
    end

    a_open_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (rx_byte == fcp_pkg::CH_OPEN)) |=>
        (in_frame_reg && (field_index_reg == '0) && (char_count_reg == '0)))
        else $error("frame open did not restart field state");

    a_idle_index: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> ((field_index_reg == '0) && (parse_phase_reg == PH_SKIP)))
        else $error("field state left over outside a frame");

endmodule

// ===== sim/fcp_frame_checker.sv =====
`timescale 1ns / 1ps
// checker for the framed ascii command parser: watches both stream channels,
// predicts each frame's five decoded values and compares them in order
// depends on fcp_pkg
module fcp_frame_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [7:0]                   s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [fcp_pkg::TDATA_W-1:0]  m_tdata,
    output int                           pending,
    output int                           fail_count
);
    import fcp_pkg::*;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd3
    } phase_e;

    typedef logic [TDATA_W-1:0] frame_word_t;

    frame_word_t frames_due[$];
    int          errors = 0;

    // predicted parser state
    bit          in_frame;
    int unsigned field_idx;
    int unsigned kept;
    bit          neg;
    phase_e      phase;
    value_t      acc [NUM_FIELDS];

    string       field_name [N_OUT] = '{"pan_rate", "tilt_rate", "laser_command",
                                        "drive_speed", "drive_radius"};

    assign fail_count = errors;

    task automatic clear_frame_state();
        in_frame  = 1'b0;
        field_idx = 0;
        kept      = 0;
        neg       = 1'b0;
        phase     = PH_SKIP;
        for (int i = 0; i < NUM_FIELDS; i++) acc[i] = '0;
    endtask

    task automatic next_field();
        kept  = 0;
        neg   = 1'b0;
        phase = PH_SKIP;
    endtask

    task automatic add_char(input logic [7:0] c);
        value_t d;
        if (field_idx >= NUM_FIELDS || kept >= KEEP_CHARS) return;
        kept++;
        if (phase == PH_SKIP) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
            if (c == CH_MINUS || c == CH_PLUS) begin
                neg   = (c == CH_MINUS);
                phase = PH_DIGITS;
                return;
            end
            phase = PH_DIGITS;
        end
        if (phase == PH_DIGITS) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = value_t'(c - CH_ZERO);
                // 16-bit wrap comes from the width of value_t
                acc[field_idx] = neg ? value_t'(acc[field_idx] * 10 - d)
                                     : value_t'(acc[field_idx] * 10 + d);
            end else begin
                phase = PH_DONE;
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] c);
        frame_word_t w;
        if (c == CH_OPEN) begin
            clear_frame_state();
            in_frame = 1'b1;
        end else if (!in_frame) begin
            // ignored outside a frame
        end else if (c == CH_CLOSE) begin
            w = '0;
            for (int j = 0; j < N_OUT; j++)
                if (j < NUM_FIELDS) w[j*VALUE_W +: VALUE_W] = acc[j];
            frames_due.push_back(w);
            in_frame  = 1'b0;
            field_idx = 0;
            next_field();
        end else if (c == CH_SEP) begin
            if (field_idx < NUM_FIELDS) field_idx++;
            next_field();
        end else if (c > CH_NINE) begin
            // abort: values are dropped, no item
            in_frame  = 1'b0;
            field_idx = 0;
            next_field();
        end else begin
            add_char(c);
        end
    endtask

    task automatic check_frame(input frame_word_t got);
        frame_word_t want;
        if (frames_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item, expected none, got %h", $time, got);
            return;
        end
        want = frames_due.pop_front();
        for (int k = 0; k < N_OUT; k++) begin
            if (got[k*VALUE_W +: VALUE_W] !== want[k*VALUE_W +: VALUE_W]) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field_name[k],
                         $signed(want[k*VALUE_W +: VALUE_W]),
                         $signed(got[k*VALUE_W +: VALUE_W]));
            end
        end
    endtask

    initial clear_frame_state();

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_frame_state();
            frames_due.delete();
        end else begin
            // results come from a '%' already parsed, never from this edge's byte
            if (m_tvalid && m_tready) check_frame(m_tdata);
            if (s_tvalid && s_tready) parse_byte(s_tdata);
        end
        pending <= frames_due.size();
    end

endmodule

// ===== sim/framed_ascii_command_parser_tb.sv =====
`timescale 1ns / 1ps
// top of the parser testbench: clock, reset, byte stimulus and verdict
// depends on fcp_pkg, framed_ascii_command_parser and fcp_frame_checker
module framed_ascii_command_parser_tb;
    import fcp_pkg::*;

    localparam int PHASE_ITEMS = 500;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;

    int                  pending;
    int                  fail_count;
    int                  tx_idle = 0;
    int                  rx_idle = 0;
    int                  bytes_sent = 0;

    framed_ascii_command_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fcp_frame_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    initial begin
        #2ms;
        $display("framed_ascii_command_parser_tb: FAIL");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt.getc(i));
    endtask

    // a byte that ends the digits of a field without touching the frame
    function automatic logic [7:0] stop_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h00, CH_NINE));
        while (c == CH_OPEN || c == CH_CLOSE || (c >= CH_ZERO && c <= CH_NINE));
        return c;
    endfunction

    task automatic send_field();
        int n;
        // occasional fully random byte may break the frame in any way
        if ($urandom_range(99) < 4) send_byte(8'($urandom_range(255)));
        n = $urandom_range(0, 2);
        repeat (n) send_byte(($urandom_range(1) == 0) ? CH_SPACE
                                                      : 8'($urandom_range(CH_TAB, CH_CR)));
        case ($urandom_range(2))
            1: send_byte(CH_MINUS);
            2: send_byte(CH_PLUS);
            default: ;
        endcase
        case ($urandom_range(9))
            0: send_text("32767");
            1: send_text("32768");
            2: send_text("65535");
            default: begin
                n = $urandom_range(0, 8);
                repeat (n) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
            end
        endcase
        if ($urandom_range(9) == 0) begin
            send_byte(stop_char());
            n = $urandom_range(0, 3);
            repeat (n) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
    endtask

    task automatic send_frame();
        int pick;
        int nf;
        logic [7:0] junk;
        pick = $urandom_range(99);
        if (pick < 80) begin
            send_byte(CH_OPEN);
            nf = $urandom_range(0, 7);
            for (int f = 0; f < nf; f++) begin
                if (f > 0) send_byte(CH_SEP);
                send_field();
            end
            send_byte(CH_CLOSE);
        end else if (pick < 90) begin
            send_byte(CH_OPEN);
            send_field();
            if ($urandom_range(1) == 0) begin
                do junk = 8'($urandom_range(8'h3A, 8'hFF));
                while (junk == CH_SEP);
                send_byte(junk);
            end else begin
                send_byte(CH_OPEN);
                send_field();
                send_byte(CH_CLOSE);
            end
        end else begin
            nf = $urandom_range(1, 4);
            repeat (nf) send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, wrap and absent fields
        send_text("#-32768|65535%");
        // plus sign, nul ending the digits, extra separators past the last field
        send_byte(CH_OPEN);
        send_text("+9");
        send_byte(8'h00);
        send_text("|||||%");
        // restart, then abort on the top byte and a stray close outside a frame
        send_text("#3#");
        send_byte(8'hFF);
        send_byte(CH_CLOSE);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin tx_idle = 37; rx_idle = 67; end
                1: begin tx_idle = 67; rx_idle = 37; end
                default: begin tx_idle = 0; rx_idle = 0; end
            endcase
            bytes_sent = 0;
            while (bytes_sent < PHASE_ITEMS) send_frame();
            // hold the sender until every result is out
            wait_results_drained();
        end

        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("framed_ascii_command_parser_tb: PASS");
        end else begin
            $display("framed_ascii_command_parser_tb: FAIL");
        end
        $finish;
    end

endmodule
